### hdl/gas_pkg.sv
// Package for the grid A* next-step core: sizes, codes, request/result
// and open-list entry types. Depends on nothing.
package gas_pkg;

    localparam int GRID_DIM   = 16;
    localparam int OPEN_DEPTH = 1024;
    localparam int ROW_W      = $clog2(GRID_DIM);
    localparam int CELL_W     = 2 * ROW_W;
    localparam int MEM_DEPTH  = 1 << CELL_W;
    localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
    localparam int COST_W     = $clog2(2 * CELL_COUNT + 2 * GRID_DIM + 4);
    localparam int CNT_W      = $clog2(OPEN_DEPTH + 1);
    localparam int STEP_W     = $clog2(CELL_COUNT);

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;
    localparam logic [1:0] KIND_FREE = 2'd0;
    localparam logic [1:0] KIND_SLOW = 2'd1;
    localparam logic [1:0] KIND_WALL = 2'd2;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_POP,
        ST_TEST,
        ST_NB,
        ST_CHK,
        ST_TR_RD,
        ST_TR_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       cmd;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic [1:0] cell_kind;
        logic [3:0] start_row;
        logic [3:0] start_col;
        logic [3:0] goal_row;
        logic [3:0] goal_col;
    } in_item_t;

    typedef struct packed {
        logic [3:0] next_row;
        logic [3:0] next_col;
        logic       reached;
    } out_item_t;

    typedef struct packed {
        logic [COST_W-1:0] f;
        logic [COST_W-1:0] g;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        dir_t              dir;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } q_ctl_t;

endpackage

### hdl/gas_cell.sv
// One slot of the sorted open list: holds one entry, shifts right on insert
// and left on removal. Depends on gas_pkg.
module gas_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  gas_pkg::q_ctl_t ctl,
    input  gas_pkg::entry_t new_entry,
    input  gas_pkg::entry_t left_entry,
    input  logic            left_valid,
    input  logic            left_ahead,
    input  gas_pkg::entry_t right_entry,
    input  logic            right_valid,
    output gas_pkg::entry_t entry,
    output logic            valid,
    output logic            ahead
);

    gas_pkg::entry_t entry_reg, entry_next;
    logic            valid_reg, valid_next;

    // an entry stays ahead of a new one unless its f is larger (ties: older first)
    assign ahead = valid_reg && (entry_reg.f <= new_entry.f);
    assign entry = entry_reg;
    assign valid = valid_reg;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.push) begin
            if (!ahead) begin
                entry_next = left_ahead ? new_entry : left_entry;
                valid_next = left_ahead ? 1'b1 : left_valid;
            end
        end else if (ctl.pop) begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### hdl/gas_queue.sv
// Open list as a chain of gas_cell slots kept in (f, insertion) order,
// with a fill count. Depends on gas_pkg and gas_cell.
module gas_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  gas_pkg::q_ctl_t ctl,
    input  gas_pkg::entry_t new_entry,
    output gas_pkg::entry_t head,
    output logic            empty
);

    gas_pkg::entry_t             cell_e [gas_pkg::OPEN_DEPTH];
    logic [gas_pkg::OPEN_DEPTH-1:0] cell_v;
    logic [gas_pkg::OPEN_DEPTH-1:0] cell_b;
    logic [gas_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        full;
    gas_pkg::q_ctl_t             cell_ctl;

    assign full  = (count_reg == gas_pkg::CNT_W'(gas_pkg::OPEN_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = cell_e[0];

    // drop an insertion into a full list and a removal from an empty one
    always_comb begin
        cell_ctl      = ctl;
        cell_ctl.push = ctl.push && !full;
        cell_ctl.pop  = ctl.pop && !empty;
    end

    always_comb begin
        count_next = count_reg;
        if (cell_ctl.clear) begin
            count_next = '0;
        end else if (cell_ctl.push) begin
            count_next = count_reg + 1'b1;
        end else if (cell_ctl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < gas_pkg::OPEN_DEPTH; i++) begin : g_cell
        gas_pkg::entry_t l_e, r_e;
        logic            l_v, l_b, r_v;
        if (i == 0) begin : g_head
            assign l_e = new_entry;
            assign l_v = 1'b0;
            assign l_b = 1'b1;
        end else begin : g_mid
            assign l_e = cell_e[i-1];
            assign l_v = cell_v[i-1];
            assign l_b = cell_b[i-1];
        end
        if (i == gas_pkg::OPEN_DEPTH - 1) begin : g_tail
            assign r_e = cell_e[i];
            assign r_v = 1'b0;
        end else begin : g_body
            assign r_e = cell_e[i+1];
            assign r_v = cell_v[i+1];
        end
        gas_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl),
            .new_entry   (new_entry),
            .left_entry  (l_e),
            .left_valid  (l_v),
            .left_ahead  (l_b),
            .right_entry (r_e),
            .right_valid (r_v),
            .entry       (cell_e[i]),
            .valid       (cell_v[i]),
            .ahead       (cell_b[i])
        );
    end

endmodule

### hdl/grid_astar_next_step_core.sv
// Top level of the grid A* next-step core: sequencer, map and parent
// memories, closed marks and result register. Depends on gas_pkg, gas_queue.
//
// The block keeps a 16 x 16 map (free, slow, wall; all free after reset).
// A write request (cmd 0) stores one cell and returns nothing.
// A query request (cmd 1) runs a 4-connected A* search from start to goal
// and returns one result: the first step toward the goal (or the start cell
// if the goal is the start or cannot be reached) and a reached flag. The
// open list is a chain of sorted slots that inserts or removes one entry a
// cycle. A query runs setup (accept and seed), then per open-list removal a
// pop and a test, per expanded cell one map read per neighbor (read then
// test), per step of the parent trace back from the goal a read and a check,
// and last the load of the result; a 16 x 16 grid needs up to 961 removals,
// 256 expansions and 255 trace steps. Requests are taken only between
// queries; a finished result waits in the output register while the next
// request is already taken.
module grid_astar_next_step_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gas_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gas_pkg::out_item_t  m_data
);

    localparam int RW = gas_pkg::ROW_W;
    localparam logic [RW-1:0] LAST = RW'(gas_pkg::GRID_DIM - 1);

    gas_pkg::state_t state_reg, state_next;

    logic [RW-1:0] sr_reg, sr_next, sc_reg, sc_next;
    logic [RW-1:0] gr_reg, gr_next, gc_reg, gc_next;
    gas_pkg::entry_t e_reg, e_next;
    gas_pkg::dir_t   k_reg, k_next;
    logic [RW-1:0]   nbr_reg, nbr_next, nbc_reg, nbc_next;
    logic            nbok_reg, nbok_next;
    logic [RW-1:0]   cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic [gas_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [3:0]      res_r_reg, res_r_next, res_c_reg, res_c_next;
    logic            reached_reg, reached_next;
    gas_pkg::out_item_t m_data_reg;
    logic            m_valid_reg;

    logic [gas_pkg::MEM_DEPTH-1:0] closed_reg;
    logic [gas_pkg::MEM_DEPTH-1:0] mapv_reg;
    logic [1:0]          map_mem [gas_pkg::MEM_DEPTH];
    gas_pkg::dir_t       par_mem [gas_pkg::MEM_DEPTH];
    logic [1:0]          map_q_reg;
    logic                mapv_q_reg;
    gas_pkg::dir_t       par_q_reg;

    gas_pkg::q_ctl_t     q_ctl;
    gas_pkg::entry_t     new_entry, q_head;
    logic                q_empty;

    logic                map_we, par_we, closed_clr, closed_set, load_out;
    logic [gas_pkg::CELL_W-1:0] map_waddr, map_raddr, par_addr, e_addr, nb_addr;
    logic [1:0]          map_wdata;
    logic [RW-1:0]       nb_r, nb_c, pv_r, pv_c;
    logic                nb_ok, pv_ok, e_closed, nb_closed, e_goal, pv_start, start_goal;
    logic [1:0]          kind_eff;
    logic [gas_pkg::COST_W-1:0] g_new, f_new, h_start;
    logic                in_grid_w, in_grid_q;

    function automatic logic [gas_pkg::COST_W-1:0] manhattan(
        input logic [RW-1:0] r, input logic [RW-1:0] c,
        input logic [RW-1:0] tr, input logic [RW-1:0] tc
    );
        logic [RW-1:0] dr, dc;
        dr = (r > tr) ? r - tr : tr - r;
        dc = (c > tc) ? c - tc : tc - c;
        return gas_pkg::COST_W'(dr) + gas_pkg::COST_W'(dc);
    endfunction

    function automatic logic on_grid(input logic [3:0] v);
        return int'(v) < gas_pkg::GRID_DIM;
    endfunction

    gas_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (q_ctl),
        .new_entry (new_entry),
        .head      (q_head),
        .empty     (q_empty)
    );

    assign s_ready = (state_reg == gas_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_grid_w = on_grid(s_data.cell_row) && on_grid(s_data.cell_col);
    assign in_grid_q = on_grid(s_data.start_row) && on_grid(s_data.start_col)
                    && on_grid(s_data.goal_row) && on_grid(s_data.goal_col);

    assign e_addr     = {e_reg.row, e_reg.col};
    assign nb_addr    = {nbr_reg, nbc_reg};
    assign e_closed   = closed_reg[e_addr];
    assign nb_closed  = closed_reg[nb_addr];
    assign e_goal     = (e_reg.row == gr_reg) && (e_reg.col == gc_reg);
    assign start_goal = (sr_reg == gr_reg) && (sc_reg == gc_reg);
    assign kind_eff   = mapv_q_reg ? map_q_reg : gas_pkg::KIND_FREE;
    assign g_new      = e_reg.g + ((kind_eff == gas_pkg::KIND_SLOW) ?
                        gas_pkg::COST_W'(2) : gas_pkg::COST_W'(1));
    assign f_new      = g_new + manhattan(nbr_reg, nbc_reg, gr_reg, gc_reg);
    assign h_start    = manhattan(sr_reg, sc_reg, gr_reg, gc_reg);

    // neighbor of the cell being expanded, in direction k
    always_comb begin
        nb_r  = e_reg.row;
        nb_c  = e_reg.col;
        nb_ok = 1'b0;
        case (k_reg)
            gas_pkg::DIR_UP: begin
                nb_r  = e_reg.row - 1'b1;
                nb_ok = (e_reg.row != '0);
            end
            gas_pkg::DIR_DOWN: begin
                nb_r  = e_reg.row + 1'b1;
                nb_ok = (e_reg.row != LAST);
            end
            gas_pkg::DIR_LEFT: begin
                nb_c  = e_reg.col - 1'b1;
                nb_ok = (e_reg.col != '0);
            end
            gas_pkg::DIR_RIGHT: begin
                nb_c  = e_reg.col + 1'b1;
                nb_ok = (e_reg.col != LAST);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // step back against the stored move of the current trace cell
    always_comb begin
        pv_r  = cur_r_reg;
        pv_c  = cur_c_reg;
        pv_ok = 1'b0;
        case (par_q_reg)
            gas_pkg::DIR_UP: begin
                pv_r  = cur_r_reg + 1'b1;
                pv_ok = (cur_r_reg != LAST);
            end
            gas_pkg::DIR_DOWN: begin
                pv_r  = cur_r_reg - 1'b1;
                pv_ok = (cur_r_reg != '0);
            end
            gas_pkg::DIR_LEFT: begin
                pv_c  = cur_c_reg + 1'b1;
                pv_ok = (cur_c_reg != LAST);
            end
            gas_pkg::DIR_RIGHT: begin
                pv_c  = cur_c_reg - 1'b1;
                pv_ok = (cur_c_reg != '0);
            end
            default: pv_ok = 1'b0;
        endcase
    end
    assign pv_start = (pv_r == sr_reg) && (pv_c == sc_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gas_pkg::ST_IDLE: begin
                if (s_valid && s_data.cmd == gas_pkg::CMD_QUERY) begin
                    state_next = in_grid_q ? gas_pkg::ST_SEED : gas_pkg::ST_DONE;
                end
            end
            gas_pkg::ST_SEED: state_next = gas_pkg::ST_POP;
            gas_pkg::ST_POP: state_next = q_empty ? gas_pkg::ST_DONE : gas_pkg::ST_TEST;
            gas_pkg::ST_TEST: begin
                if (e_closed) begin
                    state_next = gas_pkg::ST_POP;
                end else if (e_goal) begin
                    state_next = start_goal ? gas_pkg::ST_DONE : gas_pkg::ST_TR_RD;
                end else begin
                    state_next = gas_pkg::ST_NB;
                end
            end
            gas_pkg::ST_NB: state_next = gas_pkg::ST_CHK;
            gas_pkg::ST_CHK: begin
                state_next = (k_reg == gas_pkg::DIR_RIGHT) ? gas_pkg::ST_POP
                                                          : gas_pkg::ST_NB;
            end
            gas_pkg::ST_TR_RD: state_next = gas_pkg::ST_TR_CHK;
            gas_pkg::ST_TR_CHK: begin
                if (!pv_ok || pv_start ||
                    steps_reg == gas_pkg::STEP_W'(gas_pkg::CELL_COUNT - 1)) begin
                    state_next = gas_pkg::ST_DONE;
                end else begin
                    state_next = gas_pkg::ST_TR_RD;
                end
            end
            gas_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = gas_pkg::ST_IDLE;
                end
            end
            default: state_next = gas_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        sr_next      = sr_reg;
        sc_next      = sc_reg;
        gr_next      = gr_reg;
        gc_next      = gc_reg;
        e_next       = e_reg;
        k_next       = k_reg;
        nbr_next     = nbr_reg;
        nbc_next     = nbc_reg;
        nbok_next    = nbok_reg;
        cur_r_next   = cur_r_reg;
        cur_c_next   = cur_c_reg;
        steps_next   = steps_reg;
        res_r_next   = res_r_reg;
        res_c_next   = res_c_reg;
        reached_next = reached_reg;
        q_ctl        = '0;
        new_entry    = '{f: f_new, g: g_new, row: nbr_reg, col: nbc_reg, dir: k_reg};
        map_we       = 1'b0;
        map_waddr    = {RW'(s_data.cell_row), RW'(s_data.cell_col)};
        map_wdata    = s_data.cell_kind;
        map_raddr    = {nb_r, nb_c};
        par_we       = 1'b0;
        par_addr     = {cur_r_reg, cur_c_reg};
        closed_clr   = 1'b0;
        closed_set   = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            gas_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.cmd == gas_pkg::CMD_WRITE) begin
                        map_we = in_grid_w;
                    end else begin
                        sr_next      = RW'(s_data.start_row);
                        sc_next      = RW'(s_data.start_col);
                        gr_next      = RW'(s_data.goal_row);
                        gc_next      = RW'(s_data.goal_col);
                        res_r_next   = s_data.start_row;
                        res_c_next   = s_data.start_col;
                        reached_next = 1'b0;
                        closed_clr   = in_grid_q;
                        q_ctl.clear  = in_grid_q;
                    end
                end
            end
            gas_pkg::ST_SEED: begin
                q_ctl.push = 1'b1;
                new_entry  = '{f: h_start, g: '0, row: sr_reg, col: sc_reg,
                               dir: gas_pkg::DIR_UP};
            end
            gas_pkg::ST_POP: begin
                if (!q_empty) begin
                    q_ctl.pop = 1'b1;
                    e_next    = q_head;
                end
            end
            gas_pkg::ST_TEST: begin
                if (!e_closed) begin
                    closed_set = 1'b1;
                    par_we     = 1'b1;
                    par_addr   = e_addr;
                    k_next     = gas_pkg::DIR_UP;
                    if (e_goal) begin
                        reached_next = 1'b1;
                        cur_r_next   = gr_reg;
                        cur_c_next   = gc_reg;
                        steps_next   = '0;
                    end
                end
            end
            gas_pkg::ST_NB: begin
                nbr_next  = nb_r;
                nbc_next  = nb_c;
                nbok_next = nb_ok;
            end
            gas_pkg::ST_CHK: begin
                q_ctl.push = nbok_reg && !nb_closed && (kind_eff < gas_pkg::KIND_WALL);
                if (k_reg != gas_pkg::DIR_RIGHT) begin
                    k_next = gas_pkg::dir_t'(k_reg + 1'b1);
                end
            end
            gas_pkg::ST_TR_RD: begin
                par_addr = {cur_r_reg, cur_c_reg};
            end
            gas_pkg::ST_TR_CHK: begin
                if (pv_ok && pv_start) begin
                    res_r_next = 4'(cur_r_reg);
                    res_c_next = 4'(cur_c_reg);
                end else if (pv_ok) begin
                    cur_r_next = pv_r;
                    cur_c_next = pv_c;
                    steps_next = steps_reg + 1'b1;
                end
            end
            gas_pkg::ST_DONE: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: load_out = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gas_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            mapv_reg    <= '0;
            closed_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (map_we) begin
                mapv_reg[map_waddr] <= 1'b1;
            end
            if (closed_clr) begin
                closed_reg <= '0;
            end else if (closed_set) begin
                closed_reg[e_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sr_reg      <= sr_next;
        sc_reg      <= sc_next;
        gr_reg      <= gr_next;
        gc_reg      <= gc_next;
        e_reg       <= e_next;
        k_reg       <= k_next;
        nbr_reg     <= nbr_next;
        nbc_reg     <= nbc_next;
        nbok_reg    <= nbok_next;
        cur_r_reg   <= cur_r_next;
        cur_c_reg   <= cur_c_next;
        steps_reg   <= steps_next;
        res_r_reg   <= res_r_next;
        res_c_reg   <= res_c_next;
        reached_reg <= reached_next;
        if (load_out) begin
            m_data_reg <= '{next_row: res_r_reg, next_col: res_c_reg,
                            reached: reached_reg};
        end
    end

    // map memory; unwritten cells read as free through mapv_reg
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q_reg  <= map_mem[map_raddr];
        mapv_q_reg <= mapv_reg[map_raddr];
    end

    // parent move memory
    always_ff @(posedge aclk) begin
        if (par_we) begin
            par_mem[par_addr] <= e_reg.dir;
        end
        par_q_reg <= par_mem[par_addr];
    end

`ifndef SYNTHESIS
    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_ctl.push && q_ctl.pop))
        else $error("open list pushed and popped in one cycle");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctl.pop |-> !q_empty)
        else $error("pop from empty open list");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid)
        else $error("loaded result not presented");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gas_pkg::ST_POP) |-> !s_ready)
        else $error("request taken during search");
`endif

endmodule
